[rtl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

[rtl/lmfe_pkg.sv]
// Types, constants and helpers for the LED matrix frame encoder.
package lmfe_pkg;

	typedef enum logic {
		OP_COMMAND = 1'b0,
		OP_COLUMN  = 1'b1
	} op_t;

	localparam logic [7:0] CMD_HEAD  = 8'h80;
	localparam logic [7:0] DATA_HEAD = 8'hA0;

	typedef struct packed {
		logic [7:0] data;
		logic       fs;
		logic       fe;
	} res_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[7 - b] = v[b];
		end
		return r;
	endfunction

endpackage

[rtl/led_matrix_frame_encoder_unit.sv]
// LED matrix frame encoder: commands and matrix columns to a serial byte stream.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  item    | in        | item_valid, item_stall | operation, command_code, source_byte,
//          |           |                        | window_start, window_length
//  byte    | out       | byte_valid, byte_stall | out_byte, frame_start, frame_end
//
//  An item is held in one input register; its bytes go to the output register one per
//  cycle while byte_stall is low. A middle column gives one byte; a command, first or
//  last column gives two. A command that arrives mid-frame is dropped with no output.
//  The single output register sets the rate: one byte per cycle while byte_stall is low.
//  arst_n clears the column counter, carry, valid flags and byte phase.
//  byte_stall holds the output register, which then holds the input register via item_stall.
module led_matrix_frame_encoder_unit
	import lmfe_pkg::*;
#(
	parameter int COLUMNS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       operation,
	input  logic [7:0] command_code,
	input  logic [7:0] source_byte,
	input  logic [7:0] window_start,
	input  logic [7:0] window_length,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] out_byte,
	output logic       frame_start,
	output logic       frame_end
);

	localparam int CW = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

	logic          valid_s1;
	op_t           op_s1;
	logic [7:0]    cmd_s1;
	logic [7:0]    src_s1;
	logic [7:0]    wstart_s1;
	logic [7:0]    wlen_s1;

	logic          phase_q;
	logic [CW-1:0] col_idx_q;
	logic [1:0]    carry_q;
	logic [5:0]    first_q;

	logic          out_valid_q;
	res_t          out_q;

	logic [8:0]    idx9;
	logic          in_window;
	logic [7:0]    rev;
	logic          is_first;
	logic          is_last;
	logic          no_res;
	logic          two_res;
	res_t          res0;
	res_t          res1;
	logic          out_load_ok;
	logic          load_out;
	logic          retire;

	assign idx9      = {{(9 - CW){1'b0}}, col_idx_q};
	assign in_window = (idx9 >= {1'b0, wstart_s1}) &&
			((idx9 - {1'b0, wstart_s1}) < {1'b0, wlen_s1});
	assign rev       = reverse8(in_window ? src_s1 : 8'h00);
	assign is_first  = (col_idx_q == '0);
	assign is_last   = (col_idx_q == CW'(COLUMNS - 1));

	always_comb begin
		no_res  = 1'b0;
		two_res = 1'b0;
		res0    = '0;
		res1    = '0;
		case (op_s1)
			OP_COMMAND: begin
				// drop commands inside a frame
				no_res    = !is_first;
				two_res   = is_first;
				res0.data = CMD_HEAD | {3'b000, cmd_s1[7:3]};
				res0.fs   = 1'b1;
				res1.data = {cmd_s1[2:0], 5'b00000};
				res1.fe   = 1'b1;
			end
			OP_COLUMN: begin
				two_res = is_first || is_last;
				if (is_first) begin
					res0.data = DATA_HEAD;
					res0.fs   = 1'b1;
					res1.data = {2'b00, rev[7:2]};
				end else begin
					res0.data = {carry_q, rev[7:2]};
					// closing byte wraps the first column's bits behind the last carry
					res1.data = {rev[1:0], first_q};
					res1.fe   = 1'b1;
				end
			end
			default: begin
				no_res = 1'b1;
			end
		endcase
	end

	assign out_load_ok = !out_valid_q || !byte_stall;
	assign load_out    = valid_s1 && !no_res && out_load_ok;
	assign retire      = valid_s1 && (no_res || (out_load_ok && (phase_q || !two_res)));
	assign item_stall  = valid_s1 && !retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1     <= op_t'(operation);
			cmd_s1    <= command_code;
			src_s1    <= source_byte;
			wstart_s1 <= window_start;
			wlen_s1   <= window_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			col_idx_q <= '0;
			carry_q   <= 2'b00;
			first_q   <= 6'd0;
		end else begin
			if (retire) begin
				phase_q <= 1'b0;
			end else if (load_out) begin
				phase_q <= 1'b1;
			end
			// advance frame state once the column's last byte is loaded into the output register
			if (retire && (op_s1 == OP_COLUMN)) begin
				col_idx_q <= is_last ? '0 : col_idx_q + CW'(1);
				carry_q   <= rev[1:0];
				if (is_first) begin
					first_q <= rev[7:2];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= phase_q ? res1 : res0;
		end
	end

	assign byte_valid  = out_valid_q;
	assign out_byte    = out_q.data;
	assign frame_start = out_q.fs;
	assign frame_end   = out_q.fe;

endmodule

[rtl/lmfe_checker.sv]
// Port-level checker for the LED matrix frame encoder and its bind.
`include "assert_macros.svh"

module lmfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       operation,
	input logic [7:0] command_code,
	input logic [7:0] source_byte,
	input logic [7:0] window_start,
	input logic [7:0] window_length,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] out_byte,
	input logic       frame_start,
	input logic       frame_end
);

	logic        byte_xfer;
	logic        cmd_head_xfer;
	logic        hdr_xfer;
	logic [9:0]  byte_bus;
	logic [32:0] item_bus;

	assign byte_xfer     = byte_valid && !byte_stall;
	assign cmd_head_xfer = byte_xfer && frame_start && !out_byte[5];
	assign hdr_xfer      = byte_xfer && frame_start && out_byte[5];
	assign byte_bus      = {out_byte, frame_start, frame_end};
	assign item_bus      = {operation, command_code, source_byte, window_start, window_length};

	// a stalled byte holds
	`ASSERT_NEXT(a_byte_hold, clk, arst_n, byte_valid && byte_stall, byte_valid && $stable(byte_bus))

	// a stalled item holds
	`ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && item_stall, item_valid && $stable(item_bus))

	// a command head transfer is followed at once by its closing byte
	`ASSERT_NEXT(a_cmd_pair, clk, arst_n, cmd_head_xfer, byte_valid && frame_end && !frame_start)

	// the data header transfer is followed at once by the first column byte
	`ASSERT_NEXT(a_hdr_then_col, clk, arst_n, hdr_xfer, byte_valid && !frame_start && !frame_end)

endmodule

bind led_matrix_frame_encoder_unit lmfe_checker u_lmfe_checker (.*);

[test/lmfe_stream_checker.sv]
// Checker for the LED matrix frame encoder: predicts the byte stream and compares it.
module lmfe_stream_checker
	import lmfe_pkg::*;
#(
	parameter int COLUMNS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       operation,
	input  logic [7:0] command_code,
	input  logic [7:0] source_byte,
	input  logic [7:0] window_start,
	input  logic [7:0] window_length,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] out_byte,
	input  logic       frame_start,
	input  logic       frame_end,
	output int         mismatches,
	output int         pending,
	output int         bytes_seen
);

	// predictor state
	int         next_column;
	logic [1:0] carry_bits;
	logic [5:0] first_bits;
	res_t       byte_q[$];

	task automatic predict_bytes(input op_t op, input logic [7:0] cmd, input logic [7:0] src,
			input logic [7:0] wstart, input logic [7:0] wlen);
		int         idx;
		logic [7:0] col;
		logic [7:0] rev;
		if (op == OP_COMMAND) begin
			// drop commands that land inside a frame
			if (next_column != 0)
				return;
			byte_q.push_back('{data: CMD_HEAD | (cmd >> 3), fs: 1'b1, fe: 1'b0});
			byte_q.push_back('{data: cmd << 5, fs: 1'b0, fe: 1'b1});
			return;
		end
		idx = next_column;
		// full-width window compare, no wrap
		col = (idx >= int'(wstart) && (idx - int'(wstart)) < int'(wlen)) ? src : 8'h00;
		for (int b = 0; b < 8; b++)
			rev[b] = col[7 - b];
		if (idx == 0) begin
			byte_q.push_back('{data: DATA_HEAD, fs: 1'b1, fe: 1'b0});
			carry_bits = 2'b00;
			first_bits = rev[7:2];
		end
		byte_q.push_back('{data: {carry_bits, rev[7:2]}, fs: 1'b0, fe: 1'b0});
		carry_bits = rev[1:0];
		if (idx == COLUMNS - 1) begin
			byte_q.push_back('{data: {carry_bits, first_bits}, fs: 1'b0, fe: 1'b1});
			next_column = 0;
		end else begin
			next_column = idx + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			next_column = 0;
			carry_bits = 2'b00;
			first_bits = 6'd0;
			byte_q.delete();
			mismatches = 0;
			pending = 0;
			bytes_seen = 0;
		end else begin
			if (item_valid && !item_stall)
				predict_bytes(op_t'(operation), command_code, source_byte, window_start,
					window_length);
			if (byte_valid && !byte_stall) begin
				bytes_seen++;
				if (byte_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transfer: byte %02h start %b end %b", $time,
						out_byte, frame_start, frame_end);
				end else begin
					want = byte_q.pop_front();
					if (out_byte !== want.data || frame_start !== want.fs
							|| frame_end !== want.fe) begin
						mismatches++;
						$display("%0t: expected byte %02h start %b end %b, got %02h %b %b",
							$time, want.data, want.fs, want.fe, out_byte, frame_start,
							frame_end);
					end
				end
			end
			pending = byte_q.size();
		end
	end

endmodule

[test/tb_top.sv]
// Testbench top for the LED matrix frame encoder: stimulus, stall control and verdict.
module tb_top;
	import lmfe_pkg::*;

	localparam int COLUMNS = 32;
	localparam int PHASE_ITEMS = 360;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       operation = OP_COMMAND;
	logic [7:0] command_code = 8'h00;
	logic [7:0] source_byte = 8'h00;
	logic [7:0] window_start = 8'h00;
	logic [7:0] window_length = 8'h00;
	logic       byte_valid;
	logic       byte_stall = 1'b0;
	logic [7:0] out_byte;
	logic       frame_start;
	logic       frame_end;

	int mismatches;
	int pending;
	int bytes_seen;

	int gap_pct = 0;
	int stall_pct = 0;
	int column_pos = 0;
	int items_used = 0;
	int commands_sent = 0;
	int commands_dropped = 0;
	int frames_done = 0;

	led_matrix_frame_encoder_unit #(.COLUMNS(COLUMNS)) uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .command_code(command_code), .source_byte(source_byte),
		.window_start(window_start), .window_length(window_length),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.out_byte(out_byte), .frame_start(frame_start), .frame_end(frame_end)
	);

	lmfe_stream_checker #(.COLUMNS(COLUMNS)) chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .command_code(command_code), .source_byte(source_byte),
		.window_start(window_start), .window_length(window_length),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.out_byte(out_byte), .frame_start(frame_start), .frame_end(frame_end),
		.mismatches(mismatches), .pending(pending), .bytes_seen(bytes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk)
		byte_stall <= arst_n && ($urandom_range(99) < stall_pct);

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input op_t op, input logic [7:0] cmd, input logic [7:0] src,
			input logic [7:0] wstart, input logic [7:0] wlen);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		command_code <= cmd;
		source_byte <= src;
		window_start <= wstart;
		window_length <= wlen;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		// track frame position to count only items that do work
		if (op == OP_COMMAND) begin
			if (column_pos != 0) begin
				commands_dropped++;
			end else begin
				commands_sent++;
				items_used++;
			end
		end else begin
			items_used++;
			if (column_pos == COLUMNS - 1) begin
				column_pos = 0;
				frames_done++;
			end else begin
				column_pos++;
			end
		end
	endtask

	task automatic pick_window(output logic [7:0] wstart, output logic [7:0] wlen);
		case ($urandom_range(4))
			0: begin
				wstart = 8'($urandom_range(COLUMNS));
				wlen = 8'($urandom_range(COLUMNS));
			end
			1: begin
				wstart = 8'h00;
				wlen = 8'hFF;
			end
			2: begin
				wstart = 8'($urandom_range(COLUMNS - 1, 255));
				wlen = 8'($urandom_range(255));
			end
			default: begin
				wstart = 8'($urandom_range(255));
				wlen = 8'($urandom_range(255));
			end
		endcase
	endtask

	initial begin
		logic [7:0] ws;
		logic [7:0] wl;
		logic [7:0] a;
		logic [7:0] b;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: command extremes, header, bit patterns, window edges, command mid-frame
		send_item(OP_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(OP_COMMAND, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_COMMAND, 8'h81, 8'h00, 8'h00, 8'h00);
		send_item(OP_COMMAND, 8'h7E, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLUMN, 8'h00, 8'hFF, 8'h00, 8'hFF);
		send_item(OP_COLUMN, 8'h00, 8'h01, 8'h00, 8'hFF);
		send_item(OP_COLUMN, 8'h00, 8'h80, 8'h00, 8'hFF);
		send_item(OP_COMMAND, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLUMN, 8'h00, 8'hAA, 8'h00, 8'hFF);
		send_item(OP_COLUMN, 8'h00, 8'h55, 8'h00, 8'hFF);
		send_item(OP_COLUMN, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_COLUMN, 8'h00, 8'hFF, 8'h00, 8'h00);
		send_item(OP_COLUMN, 8'h00, 8'hFF, 8'h07, 8'h01);
		send_item(OP_COLUMN, 8'h00, 8'hFF, 8'h07, 8'h01);
		send_item(OP_COLUMN, 8'h00, 8'hC3, 8'h08, 8'h01);
		send_item(OP_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLUMN, 8'h00, 8'h3C, 8'h00, 8'h10);
		send_item(OP_COLUMN, 8'h00, 8'h0F, 8'hF0, 8'h10);

		// random: four idle/stall phases, mostly well-formed frames with random content
		ws = 8'h00;
		wl = 8'hFF;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 61; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 61; end
				default: begin gap_pct = 38; stall_pct = 38; end
			endcase
			while (items_used < 18 + (phase + 1) * PHASE_ITEMS) begin
				a = 8'($urandom_range(255));
				b = 8'($urandom_range(255));
				if (column_pos == 0) begin
					if ($urandom_range(99) < 35) begin
						send_item(OP_COMMAND, a, b, 8'($urandom), 8'($urandom));
					end else begin
						pick_window(ws, wl);
						send_item(OP_COLUMN, a, b, ws, wl);
					end
				end else if ($urandom_range(99) < 6) begin
					send_item(OP_COMMAND, a, b, ws, wl);
				end else if ($urandom_range(99) < 5) begin
					// window changed mid-frame
					pick_window(ws, wl);
					send_item(OP_COLUMN, a, b, ws, wl);
				end else begin
					send_item(OP_COLUMN, a, b, ws, wl);
				end
			end
		end
		item_valid <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Run covered %0d items: %0d commands, %0d full frames, %0d dropped mid-frame",
			items_used, commands_sent, frames_done, commands_dropped);
		$display("Checked %0d output bytes under four idle/stall mixes", bytes_seen);
		if (mismatches == 0) begin
			$display("[led_matrix_frame_encoder_unit] OK");
		end else begin
			$display("[led_matrix_frame_encoder_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d bytes still pending", pending);
		$display("[led_matrix_frame_encoder_unit] ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/lmfe_pkg.sv
rtl/led_matrix_frame_encoder_unit.sv
rtl/lmfe_checker.sv
test/lmfe_stream_checker.sv
test/tb_top.sv
